@@ rtl/otpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// otpfa_pkg: shared types and constants
// Frame table sizing, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package otpfa_pkg;

    localparam int unsigned FRAME_COUNT = 16384;
    localparam int unsigned MAX_DUMP    = 64;
    localparam int unsigned AW          = $clog2(FRAME_COUNT);
    localparam int unsigned CW          = AW + 1;

    localparam logic [15:0] KERNEL_TAG  = 16'hFFFF;
    localparam logic [15:0] FIRST_RESET = 16'h0000;
    localparam logic [15:0] LIMIT_RESET = 16'hE000;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_DUMP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAME  = 2'd1,
        ST_BAD_PAGE  = 2'd2,
        ST_BAD_COUNT = 2'd3
    } t_status;

    typedef enum logic {
        REG_FIRST_PAGE = 1'b0,
        REG_LIMIT_PAGE = 1'b1
    } t_reg;

    typedef struct packed {
        logic clear;
        logic take;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic res_now;
    } t_sts;

    // neighbor is acceptable to a process requester
    function automatic logic frame_ok(input logic [15:0] tag, input logic [15:0] req);
        return (tag == req) || (tag == 16'd0) || (tag == KERNEL_TAG);
    endfunction

endpackage

@@ rtl/owner_tagged_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// owner_tagged_page_frame_allocator: page frame table with owner tags
// Load, allocate, free and dump items over a 16384-entry frame table.
// ----------------------------------------------------------------------------
// After reset the block clears the owner table, one entry per cycle, before it
// accepts its first item; config writes are taken meanwhile.
// One item is in flight at a time. Allocate, free and dump read the frame
// table linearly through one read port per memory, one entry per cycle except
// while a dump waits on a result transfer. A dump restarts the scan after the
// result transfer of every frame it emits before the final one. Unloaded page
// entries read as unknown.
module owner_tagged_page_frame_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // slot[13:0] page_number[29:14] owner[45:30] count[52:46]
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // status[1:0] frame_page[17:2] frame_owner[33:18]
                                         // has_entry[34]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import otpfa_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  status;
    logic [15:0] frame_page, frame_owner;
    logic        has_entry, last;

    assign o_cfg_ready = 1'b1;

    otpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_out_last  (last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    otpfa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_s_axis_tuser),
        .i_slot        (i_s_axis_tdata[13:0]),
        .i_page        (i_s_axis_tdata[29:14]),
        .i_owner       (i_s_axis_tdata[45:30]),
        .i_count       (i_s_axis_tdata[52:46]),
        .o_status      (status),
        .o_frame_page  (frame_page),
        .o_frame_owner (frame_owner),
        .o_has_entry   (has_entry),
        .o_last        (last)
    );

    assign o_m_axis_tdata = {5'd0, has_entry, frame_owner, frame_page, status};
    assign o_m_axis_tlast = last;

endmodule

@@ rtl/otpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// otpfa_ctrl: sequencing state machine
// Clear pass after reset, item intake, table scan and result handoff.
// ----------------------------------------------------------------------------
module otpfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_out_last,
    input  otpfa_pkg::t_sts   i_sts,
    output otpfa_pkg::t_cmd   o_cmd
);
    import otpfa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_sts.res_now) begin
                            r_state     <= S_OUT;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_sts.res_now) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= i_out_last ? S_IDLE : S_SCAN;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.clear = (r_state == S_CLEAR);
    assign o_cmd.take  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan  = (r_state == S_SCAN);

endmodule

@@ rtl/otpfa_dp.sv @@
// ----------------------------------------------------------------------------
// otpfa_dp: frame table datapath
// Owner and page memories, scan pointer, neighbor window, dump pending entry,
// config registers and result register.
// ----------------------------------------------------------------------------
module otpfa_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  otpfa_pkg::t_cmd   i_cmd,
    output otpfa_pkg::t_sts   o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_mode,
    input  logic [13:0]       i_slot,
    input  logic [15:0]       i_page,
    input  logic [15:0]       i_owner,
    input  logic [6:0]        i_count,
    output logic [1:0]        o_status,
    output logic [15:0]       o_frame_page,
    output logic [15:0]       o_frame_owner,
    output logic              o_has_entry,
    output logic              o_last
);
    import otpfa_pkg::*;

    localparam logic [CW-1:0] N_FRAMES = CW'(FRAME_COUNT);
    localparam logic [CW-1:0] N_ALLOC  = CW'(FRAME_COUNT + 1);
    localparam logic [6:0]    DUMP_MAX = 7'(MAX_DUMP);

    logic [15:0] owner_mem [FRAME_COUNT];
    logic [15:0] page_mem  [FRAME_COUNT];

    logic [15:0] r_first, r_limit;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_page, n_page;
    logic [15:0] r_req, n_req;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_n, n_n;
    logic [CW-1:0] r_addr, n_addr;
    logic        r_rv, n_rv;
    logic [CW-1:0] r_ridx, n_ridx;
    logic [15:0] r_w0, n_w0, r_w1, n_w1, r_pw0, n_pw0;
    logic        r_pend_v, n_pend_v;
    logic [15:0] r_pend_page, n_pend_page, r_pend_own, n_pend_own;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_fpage, n_fpage, r_fown, n_fown;
    logic        r_has, n_has, r_last, n_last;
    logic [15:0] rd_own, rd_page;

    logic          own_we, page_we, issue, res_now, cand;
    logic [AW-1:0] own_wa, page_wa;
    logic [15:0]   own_wd, right;
    logic [CW-1:0] slot_ext, cidx;

    always_comb begin
        slot_ext = CW'(i_slot);
        cidx     = r_ridx - CW'(1);
        right    = (r_ridx == N_FRAMES) ? 16'd0 : rd_own;
        if (r_ridx == CW'(1)) begin
            cand = (r_w0 == 16'd0) && ((right == 16'd0) || (right == r_req));
        end else begin
            cand = (r_w0 == 16'd0) &&
                   ((r_req == KERNEL_TAG) || (frame_ok(r_w1, r_req) && frame_ok(right, r_req)));
        end
    end

    always_comb begin
        n_mode = r_mode;  n_page = r_page;  n_req = r_req;  n_cnt = r_cnt;
        n_n = r_n;  n_addr = r_addr;  n_rv = 1'b0;  n_ridx = r_ridx;
        n_w0 = r_w0;  n_w1 = r_w1;  n_pw0 = r_pw0;
        n_pend_v = r_pend_v;  n_pend_page = r_pend_page;  n_pend_own = r_pend_own;
        n_status = r_status;  n_fpage = r_fpage;  n_fown = r_fown;
        n_has = r_has;  n_last = r_last;
        own_we = 1'b0;  own_wa = r_addr[AW-1:0];  own_wd = 16'd0;
        page_we = 1'b0;  page_wa = slot_ext[AW-1:0];
        issue = 1'b0;  res_now = 1'b0;

        if (i_cmd.clear) begin
            own_we = 1'b1;
            n_addr = r_addr + CW'(1);
        end else if (i_cmd.take) begin
            n_mode = i_mode;  n_page = i_page;  n_req = i_owner;
            n_cnt = (i_count > DUMP_MAX) ? DUMP_MAX : i_count;
            n_n = 7'd0;  n_addr = '0;  n_pend_v = 1'b0;
            n_status = ST_OK;  n_fpage = 16'd0;  n_fown = 16'd0;
            n_has = 1'b0;  n_last = 1'b1;
            unique case (t_mode'(i_mode))
                MODE_LOAD: begin
                    res_now = 1'b1;
                    if (slot_ext < N_FRAMES) begin
                        own_we  = 1'b1;
                        own_wa  = slot_ext[AW-1:0];
                        page_we = 1'b1;
                    end
                end
                MODE_ALLOC: begin
                end
                MODE_FREE: begin
                    if ((i_page < r_first) || (i_page >= r_limit)) begin
                        res_now  = 1'b1;
                        n_status = ST_BAD_PAGE;
                    end
                end
                MODE_DUMP: begin
                    if (i_count == 7'd0) begin
                        res_now  = 1'b1;
                        n_status = ST_BAD_COUNT;
                    end
                end
            endcase
        end else if (i_cmd.scan) begin
            unique case (t_mode'(r_mode))
                MODE_ALLOC: begin
                    // window: w1 = owner[c-1], w0 = owner[c], incoming = owner[c+1]
                    if (r_rv) begin
                        n_w1 = r_w0;  n_w0 = rd_own;  n_pw0 = rd_page;
                    end
                    if (r_rv && (r_ridx != '0) && cand) begin
                        own_we   = 1'b1;
                        own_wa   = cidx[AW-1:0];
                        own_wd   = r_req;
                        res_now  = 1'b1;
                        n_status = ST_OK;  n_fpage = r_pw0;  n_fown = r_req;
                        n_has    = 1'b1;   n_last = 1'b1;
                    end else if (!r_rv && (r_addr == N_ALLOC)) begin
                        res_now  = 1'b1;
                        n_status = ST_NO_FRAME;  n_fpage = 16'd0;  n_fown = 16'd0;
                        n_has    = 1'b0;  n_last = 1'b1;
                    end else if (r_addr != N_ALLOC) begin
                        issue = 1'b1;
                    end
                end
                MODE_FREE: begin
                    if (r_rv && (rd_page == r_page)) begin
                        own_we  = 1'b1;
                        own_wa  = r_ridx[AW-1:0];
                        res_now = 1'b1;
                    end else if (!r_rv && (r_addr == N_FRAMES)) begin
                        res_now = 1'b1;
                    end else if (r_addr != N_FRAMES) begin
                        issue = 1'b1;
                    end
                end
                MODE_DUMP: begin
                    // one owned frame is held back so the final one can carry last
                    if (r_pend_v && (r_n == r_cnt)) begin
                        res_now  = 1'b1;
                        n_status = ST_OK;  n_fpage = r_pend_page;  n_fown = r_pend_own;
                        n_has    = 1'b1;   n_last = 1'b1;
                    end else if (r_rv && (rd_own != 16'd0)) begin
                        n_n = r_n + 7'd1;
                        n_pend_v = 1'b1;  n_pend_page = rd_page;  n_pend_own = rd_own;
                        if (r_pend_v) begin
                            res_now  = 1'b1;
                            n_status = ST_OK;  n_fpage = r_pend_page;  n_fown = r_pend_own;
                            n_has    = 1'b1;   n_last = 1'b0;
                            n_addr   = r_ridx + CW'(1);
                        end else if (((r_n + 7'd1) != r_cnt) && (r_addr != N_FRAMES)) begin
                            issue = 1'b1;
                        end
                    end else if (!r_rv && (r_addr == N_FRAMES)) begin
                        res_now  = 1'b1;
                        n_status = ST_OK;
                        n_fpage  = r_pend_v ? r_pend_page : 16'd0;
                        n_fown   = r_pend_v ? r_pend_own : 16'd0;
                        n_has    = r_pend_v;
                        n_last   = 1'b1;
                    end else if (r_addr != N_FRAMES) begin
                        issue = 1'b1;
                    end
                end
                MODE_LOAD: begin
                    res_now = 1'b1;
                end
            endcase
        end

        if (issue) begin
            n_rv   = 1'b1;
            n_ridx = r_addr;
            n_addr = r_addr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            owner_mem[own_wa] <= own_wd;
        end
        rd_own <= owner_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            page_mem[page_wa] <= i_page;
        end
        rd_page <= page_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= FIRST_RESET;
            r_limit  <= LIMIT_RESET;
            r_addr   <= '0;
            r_rv     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_FIRST_PAGE: r_first <= i_cfg_data;
                    REG_LIMIT_PAGE: r_limit <= i_cfg_data;
                endcase
            end
            r_addr   <= n_addr;
            r_rv     <= n_rv;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;  r_page <= n_page;  r_req <= n_req;  r_cnt <= n_cnt;
        r_n <= n_n;  r_ridx <= n_ridx;
        r_w0 <= n_w0;  r_w1 <= n_w1;  r_pw0 <= n_pw0;
        r_pend_page <= n_pend_page;  r_pend_own <= n_pend_own;
        r_status <= n_status;  r_fpage <= n_fpage;  r_fown <= n_fown;
        r_has <= n_has;  r_last <= n_last;
    end

    assign o_sts.clear_done = i_cmd.clear && (r_addr == N_FRAMES - CW'(1));
    assign o_sts.res_now    = res_now;
    assign o_status         = r_status;
    assign o_frame_page     = r_fpage;
    assign o_frame_owner    = r_fown;
    assign o_has_entry      = r_has;
    assign o_last           = r_last;

endmodule

@@ bench/owner_tagged_page_frame_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// owner_tagged_page_frame_allocator_tb: self-checking bench for the allocator
// Loads the low frames, then runs directed and random load, allocate, free and
// dump items under random idling on both streams. A scoreboard keeps its own
// copy of the frame table, predicts every result and checks them in order.
// ----------------------------------------------------------------------------
module owner_tagged_page_frame_allocator_tb;
    import otpfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRELOAD = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;   // slot[13:0] page_number[29:14] owner[45:30] count[52:46]
    logic [1:0]  i_s_axis_tuser;   // mode[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // status[1:0] frame_page[17:2] frame_owner[33:18]
                                   // has_entry[34]
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    owner_tagged_page_frame_allocator uut (.*);

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;

    typedef struct {
        t_status     status;
        logic [15:0] page;
        logic [15:0] owner;
        logic        has;
        logic        last;
    } t_frame_res;

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class frame_scoreboard;
        logic [15:0] owner_tab[FRAME_COUNT];
        logic [15:0] page_tab[FRAME_COUNT];
        bit          loaded[FRAME_COUNT];
        logic [15:0] first_pg;
        logic [15:0] limit_pg;
        t_frame_res  pending_q[$];

        function void clear_state();
            foreach (owner_tab[i]) begin
                owner_tab[i] = 16'd0;
                page_tab[i]  = 16'd0;
                loaded[i]    = 1'b0;
            end
            first_pg = FIRST_RESET;
            limit_pg = LIMIT_RESET;
        endfunction

        function void set_reg(t_reg idx, logic [15:0] val);
            if (idx == REG_FIRST_PAGE) first_pg = val;
            else limit_pg = val;
        endfunction

        function void push(t_status st, logic [15:0] pg, logic [15:0] ow, logic has,
                           logic lst);
            t_frame_res r;
            r.status = st; r.page = pg; r.owner = ow; r.has = has; r.last = lst;
            pending_q.push_back(r);
        endfunction

        function bit fits(logic [15:0] tag, logic [15:0] req);
            return tag == req || tag == 16'd0 || tag == KERNEL_TAG;
        endfunction

        function int pick_frame(logic [15:0] req);
            logic [15:0] right;
            if (owner_tab[0] == 0 && (owner_tab[1] == 0 || owner_tab[1] == req)) return 0;
            for (int i = 1; i < FRAME_COUNT; i++) begin
                if (owner_tab[i] != 0) continue;
                if (req == KERNEL_TAG) return i;
                // the last frame has no right neighbor: treat it as free
                right = (i + 1 < FRAME_COUNT) ? owner_tab[i + 1] : 16'd0;
                if (fits(owner_tab[i - 1], req) && fits(right, req)) return i;
            end
            return -1;
        endfunction

        // a free may only compare against loaded page entries
        function bit free_scans_loaded(logic [15:0] pg);
            if (pg < first_pg || pg >= limit_pg) return 1'b1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!loaded[i]) return 1'b0;
                if (page_tab[i] == pg) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(t_mode mode, logic [13:0] slot, logic [15:0] pg,
                                logic [15:0] req, logic [6:0] cnt);
            int f;
            int lim;
            int idx_q[$];
            case (mode)
                MODE_LOAD: begin
                    page_tab[slot]  = pg;
                    owner_tab[slot] = 16'd0;
                    loaded[slot]    = 1'b1;
                    push(ST_OK, 0, 0, 0, 1);
                end
                MODE_ALLOC: begin
                    f = pick_frame(req);
                    if (f < 0) push(ST_NO_FRAME, 0, 0, 0, 1);
                    else begin
                        owner_tab[f] = req;
                        push(ST_OK, page_tab[f], req, 1, 1);
                    end
                end
                MODE_FREE: begin
                    if (pg < first_pg || pg >= limit_pg) push(ST_BAD_PAGE, 0, 0, 0, 1);
                    else begin
                        for (int i = 0; i < FRAME_COUNT; i++)
                            if (page_tab[i] == pg) begin
                                owner_tab[i] = 16'd0;
                                break;
                            end
                        push(ST_OK, 0, 0, 0, 1);
                    end
                end
                default: begin
                    if (cnt == 0) push(ST_BAD_COUNT, 0, 0, 0, 1);
                    else begin
                        lim = (cnt > MAX_DUMP) ? MAX_DUMP : cnt;
                        for (int i = 0; i < FRAME_COUNT && idx_q.size() < lim; i++)
                            if (owner_tab[i] != 0) idx_q.push_back(i);
                        if (idx_q.size() == 0) push(ST_OK, 0, 0, 0, 1);
                        else
                            foreach (idx_q[k])
                                push(ST_OK, page_tab[idx_q[k]], owner_tab[idx_q[k]], 1,
                                     k == idx_q.size() - 1);
                    end
                end
            endcase
        endfunction

        task check_result(logic [39:0] data, logic lst);
            t_frame_res w;
            if (pending_q.size() == 0) begin
                report("unexpected result", data[17:2], 16'd0);
                return;
            end
            w = pending_q.pop_front();
            if (data[1:0] != w.status) report("status", 16'(data[1:0]), 16'(w.status));
            if (data[17:2] != w.page) report("frame_page", data[17:2], w.page);
            if (data[33:18] != w.owner) report("frame_owner", data[33:18], w.owner);
            if (data[34] != w.has) report("has_entry", 16'(data[34]), 16'(w.has));
            if (lst != w.last) report("last", 16'(lst), 16'(w.last));
        endtask
    endclass

    frame_scoreboard sb = new();

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // result side: random backpressure with an optional long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                recv_hold--;
            end else
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast);

    task automatic send_item(t_mode mode, logic [13:0] slot, logic [15:0] pg,
                             logic [15:0] req, logic [6:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {3'b000, cnt, req, pg, slot};
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        sb.note_item(mode, slot, pg, req, cnt);
        @(negedge i_clk);
    endtask

    // the frame an allocate grants gets its page entry loaded first
    task automatic send_alloc(logic [15:0] req);
        int f;
        f = sb.pick_frame(req);
        if (f >= 0 && !sb.loaded[f])
            send_item(MODE_LOAD, 14'(f), 16'($urandom), 16'($urandom), 7'($urandom));
        send_item(MODE_ALLOC, 14'($urandom), 16'($urandom), req, 7'($urandom));
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_window(logic [15:0] first, logic [15:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FIRST_PAGE;
        i_cfg_data  <= first;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_FIRST_PAGE, first);
        @(negedge i_clk);
        i_cfg_index <= REG_LIMIT_PAGE;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_LIMIT_PAGE, limit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_owner();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'd1;
            3, 4:    return 16'd2;
            5:       return 16'd3;
            6, 7:    return KERNEL_TAG;
            8:       return 16'd0;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_items(int n);
        int r;
        logic [15:0] pg;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_item(MODE_LOAD, 14'($urandom_range(0, FRAME_COUNT - 1)),
                          16'($urandom_range(0, 65535)), 16'($urandom), 7'($urandom));
            else if (r < 55)
                send_alloc(pick_owner());
            else if (r < 85) begin
                // mostly free a page that some low frame actually holds
                if ($urandom_range(0, 3) != 0)
                    send_item(MODE_FREE, 14'($urandom),
                              sb.page_tab[$urandom_range(0, PRELOAD - 1)], 16'($urandom),
                              7'($urandom));
                else begin
                    pg = 16'($urandom_range(0, 65535));
                    if (!sb.free_scans_loaded(pg))
                        pg = sb.page_tab[$urandom_range(0, PRELOAD - 1)];
                    send_item(MODE_FREE, 14'($urandom), pg, 16'($urandom), 7'($urandom));
                end
            end else
                send_item(MODE_DUMP, 14'($urandom), 16'($urandom), 16'($urandom),
                          7'($urandom_range(0, 100)));
        end
    endtask

    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = MODE_LOAD;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_FIRST_PAGE;
        i_cfg_data      = '0;
        sb.clear_state();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // low frames get loaded first; frees in range compare only against loaded entries
        for (int i = 0; i < PRELOAD; i++)
            send_item(MODE_LOAD, 14'(i), 16'((i * 7 + 3) ^ (i << 9)), 16'(~i), 7'(i));
        drain();

        send_idle_pct = 13;
        recv_idle_pct = 88;
        send_item(MODE_FREE, 0, 16'hE000, 0, 0);     // at limit under reset window
        send_alloc(16'd1);                           // frame zero, neighbor free
        send_alloc(16'd1);                           // left neighbor is the requester
        send_alloc(16'd2);                           // must skip past owner 1
        send_alloc(KERNEL_TAG);                      // kernel takes first free
        send_alloc(16'hFFFE);
        send_item(MODE_DUMP, 0, 0, 0, 7'd0);         // bad count
        send_item(MODE_DUMP, 0, 0, 0, 7'd2);
        send_item(MODE_DUMP, 0, 0, 0, 7'd127);       // saturates
        drain();
        set_window(16'd0, 16'hFFFF);
        send_item(MODE_FREE, 0, sb.page_tab[0], 0, 0);
        send_item(MODE_FREE, 0, 16'hFFFF, 0, 0);     // at limit
        send_item(MODE_LOAD, 14'd0, 16'd0, 0, 0);
        send_item(MODE_FREE, 0, 16'd0, 0, 0);        // lowest page, in range
        send_alloc(16'd0);                           // owner zero leaves frame free
        send_alloc(16'd0);
        send_item(MODE_LOAD, 14'h3FFF, 16'hFFFF, 16'hFFFF, 7'h7F);
        for (int i = 0; i < 8; i++) begin
            send_item(MODE_FREE, 0, sb.page_tab[i], 0, 0);
            send_item(MODE_FREE, 0, sb.page_tab[i], 0, 0);
        end
        drain();
        // nothing owned at all
        send_item(MODE_DUMP, 0, 0, 0, 7'd64);
        send_alloc(16'd5);
        drain();

        set_window(16'h0100, 16'h4000);
        random_items(10);
        // long receiver hold-off while loads keep coming
        recv_hold = 400;
        for (int i = 0; i < 6; i++)
            send_item(MODE_LOAD, 14'($urandom_range(0, 63)), 16'($urandom), 0, 0);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 13;
        set_window(16'hFFFF, 16'd0);
        random_items(8);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(16'd0, 16'hFFFF);
        random_items(10);
        drain();
        set_window(16'd3, 16'hC000);
        random_items(8);
        send_item(MODE_DUMP, 0, 0, 0, 7'd64);
        drain();

        repeat (50) @(negedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
rtl/otpfa_pkg.sv
rtl/otpfa_ctrl.sv
rtl/otpfa_dp.sv
rtl/owner_tagged_page_frame_allocator.sv
bench/owner_tagged_page_frame_allocator_tb.sv
